### hw/rtl/rsa_pkg.sv
// Shared types and constants for the 16-bit RPN stack unit.
package rsa_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned CMD_W  = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 4'd0,
        CMD_EMPTY = 4'd1,
        CMD_POP   = 4'd2,
        CMD_TOP   = 4'd3,
        CMD_SHL   = 4'd4,
        CMD_SHR   = 4'd5,
        CMD_OR    = 4'd6,
        CMD_AND   = 4'd7,
        CMD_ADD   = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        SHIFT_HOLD,
        SHIFT_PUSH,
        SHIFT_POP
    } t_shift_op;

    typedef struct packed {
        t_shift_op top_op;
        t_shift_op rest_op;
    } t_shift_ctl;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic              has_value;
        logic [DATA_W-1:0] top_value;
        logic              overflow;
    } t_out_word;

endpackage

### hw/rtl/rsa_cell.sv
// One stack cell: holds an entry and shifts toward or away from the top.
module rsa_cell (
    input  logic                       i_clk,
    input  rsa_pkg::t_shift_op         i_op,
    input  logic [rsa_pkg::DATA_W-1:0] i_above,
    input  logic [rsa_pkg::DATA_W-1:0] i_below,
    output logic [rsa_pkg::DATA_W-1:0] o_data
);

    logic [rsa_pkg::DATA_W-1:0] r_data;
    logic [rsa_pkg::DATA_W-1:0] n_data;

    always_comb begin
        case (i_op)
            rsa_pkg::SHIFT_PUSH: n_data = i_above;
            rsa_pkg::SHIFT_POP:  n_data = i_below;
            default:             n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### hw/rtl/rsa_alu.sv
// Two-operand unit: combines top a and next b.
module rsa_alu (
    input  logic [rsa_pkg::CMD_W-1:0]  i_cmd,
    input  logic [rsa_pkg::DATA_W-1:0] i_a,
    input  logic [rsa_pkg::DATA_W-1:0] i_b,
    output logic [rsa_pkg::DATA_W-1:0] o_result
);

    logic big_shift;

    assign big_shift = (i_a[rsa_pkg::DATA_W-1:4] != '0);

    always_comb begin
        case (i_cmd)
            rsa_pkg::CMD_SHL: o_result = big_shift ? '0 : (i_b << i_a[3:0]);
            rsa_pkg::CMD_SHR: o_result = big_shift ? '0 : (i_b >> i_a[3:0]);
            rsa_pkg::CMD_OR:  o_result = i_a | i_b;
            rsa_pkg::CMD_AND: o_result = i_a & i_b;
            default:          o_result = i_a + i_b;
        endcase
    end

endmodule

### hw/rtl/rpn_stack_alu_16bit_unit.sv
// Top level of the 16-bit RPN stack unit: cell chain, counter and result register.
// The stack is a chain of STACK_DEPTH register cells with the top in cell 0;
// a push shifts every cell one place down, a pop shifts them one place up,
// and a two-operand command writes its result into cell 0 and shifts the rest
// up, so only cells 0 and 1 are ever read. A new word is accepted each cycle
// while the result register is free or being drained; the rate is set by the
// read-modify-shift of the top two cells. Each input word yields exactly one
// result word. No clearing pass: reset only clears the counter and output valid.
module rpn_stack_alu_16bit_unit #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rsa_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rsa_pkg::t_out_word o_out_word
);

    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_out_valid;
    logic                      n_out_valid;
    rsa_pkg::t_out_word        r_out_word;
    rsa_pkg::t_out_word        n_out_word;
    rsa_pkg::t_shift_ctl       w_ctl;
    logic [rsa_pkg::DATA_W-1:0] w_cell [STACK_DEPTH];
    logic [rsa_pkg::DATA_W-1:0] w_top_in;
    logic [rsa_pkg::DATA_W-1:0] w_alu_result;
    logic                      w_accept;
    logic                      w_full;
    logic                      w_has1;
    logic                      w_has2;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(STACK_DEPTH));
    assign w_has1     = (r_count != '0);
    assign w_has2     = (r_count >= CNT_W'(2));

    rsa_alu u_alu (
        .i_cmd    (i_in_word.cmd),
        .i_a      (w_cell[0]),
        .i_b      (w_cell[1]),
        .o_result (w_alu_result)
    );

    always_comb begin
        n_count         = r_count;
        w_ctl.top_op    = rsa_pkg::SHIFT_HOLD;
        w_ctl.rest_op   = rsa_pkg::SHIFT_HOLD;
        w_top_in        = w_alu_result;
        n_out_word      = '0;
        case (i_in_word.cmd)
            rsa_pkg::CMD_LOAD: begin
                w_top_in = i_in_word.value;
                if (w_full) begin
                    n_out_word.overflow = 1'b1;
                end else begin
                    n_count              = r_count + CNT_W'(1);
                    w_ctl.top_op         = rsa_pkg::SHIFT_PUSH;
                    w_ctl.rest_op        = rsa_pkg::SHIFT_PUSH;
                    n_out_word.has_value = 1'b1;
                    n_out_word.top_value = i_in_word.value;
                end
            end
            rsa_pkg::CMD_EMPTY: begin
                n_count = '0;
            end
            rsa_pkg::CMD_POP: begin
                if (w_has1) begin
                    n_count       = r_count - CNT_W'(1);
                    w_ctl.top_op  = rsa_pkg::SHIFT_POP;
                    w_ctl.rest_op = rsa_pkg::SHIFT_POP;
                end
                if (w_has2) begin
                    n_out_word.has_value = 1'b1;
                    n_out_word.top_value = w_cell[1];
                end
            end
            rsa_pkg::CMD_TOP: begin
                if (w_has1) begin
                    n_out_word.has_value = 1'b1;
                    n_out_word.top_value = w_cell[0];
                end
            end
            rsa_pkg::CMD_SHL, rsa_pkg::CMD_SHR, rsa_pkg::CMD_OR,
            rsa_pkg::CMD_AND, rsa_pkg::CMD_ADD: begin
                if (w_has2) begin
                    n_count              = r_count - CNT_W'(1);
                    w_ctl.top_op         = rsa_pkg::SHIFT_PUSH;
                    w_ctl.rest_op        = rsa_pkg::SHIFT_POP;
                    n_out_word.has_value = 1'b1;
                    n_out_word.top_value = w_alu_result;
                end
            end
            default: begin
                n_out_word.has_value = 1'b1;
            end
        endcase
        if (!w_accept) begin
            n_count       = r_count;
            w_ctl.top_op  = rsa_pkg::SHIFT_HOLD;
            w_ctl.rest_op = rsa_pkg::SHIFT_HOLD;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_top
                rsa_cell u_cell (
                    .i_clk   (i_clk),
                    .i_op    (w_ctl.top_op),
                    .i_above (w_top_in),
                    .i_below (w_cell[1]),
                    .o_data  (w_cell[0])
                );
            end else if (gi == STACK_DEPTH - 1) begin : g_bottom
                rsa_cell u_cell (
                    .i_clk   (i_clk),
                    .i_op    (w_ctl.rest_op),
                    .i_above (w_cell[gi-1]),
                    .i_below ('0),
                    .o_data  (w_cell[gi])
                );
            end else begin : g_mid
                rsa_cell u_cell (
                    .i_clk   (i_clk),
                    .i_op    (w_ctl.rest_op),
                    .i_above (w_cell[gi-1]),
                    .i_below (w_cell[gi+1]),
                    .o_data  (w_cell[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### test/rpn_stack_alu_16bit_unit_test.sv
// Testbench for the 16-bit RPN stack unit: directed and random command streams checked against a stack predictor.
`timescale 1ns / 1ps

module rpn_stack_alu_16bit_unit_test;

    localparam int unsigned DEPTH = 16;
    localparam int unsigned CMD_W = rsa_pkg::CMD_W;
    localparam int unsigned DATA_W = rsa_pkg::DATA_W;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 4'd15;
    localparam int unsigned STALL_LIMIT = 1000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    rsa_pkg::t_in_word  i_in_word;
    logic               o_out_valid;
    logic               i_out_ready;
    rsa_pkg::t_out_word o_out_word;

    logic [DATA_W-1:0]  model_stack [DEPTH];
    int unsigned        model_count;
    rsa_pkg::t_out_word pending_results[$];
    int unsigned        mismatch_cnt;
    int unsigned        quiet_cycles;
    int unsigned        gen_depth;
    bit                 idle_on;
    bit                 stall_on;

    rpn_stack_alu_16bit_unit #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [DATA_W-1:0] combine_top(logic [CMD_W-1:0] cmd,
                                                      logic [DATA_W-1:0] a,
                                                      logic [DATA_W-1:0] b);
        case (cmd)
            rsa_pkg::CMD_SHL: combine_top = (a >= 16) ? '0 : DATA_W'(b << a[3:0]);
            rsa_pkg::CMD_SHR: combine_top = (a >= 16) ? '0 : (b >> a[3:0]);
            rsa_pkg::CMD_OR:  combine_top = a | b;
            rsa_pkg::CMD_AND: combine_top = a & b;
            default:          combine_top = a + b;
        endcase
    endfunction

    function automatic rsa_pkg::t_out_word stack_result(rsa_pkg::t_in_word w);
        rsa_pkg::t_out_word res;
        logic [DATA_W-1:0]  r;
        res = '0;
        case (w.cmd)
            rsa_pkg::CMD_LOAD: begin
                if (model_count >= DEPTH) begin
                    res.overflow = 1'b1;
                end else begin
                    model_stack[model_count] = w.value;
                    model_count++;
                    res.has_value = 1'b1;
                    res.top_value = w.value;
                end
            end
            rsa_pkg::CMD_EMPTY: model_count = 0;
            rsa_pkg::CMD_POP, rsa_pkg::CMD_TOP: begin
                if (w.cmd == rsa_pkg::CMD_POP && model_count > 0) model_count--;
                if (model_count > 0) begin
                    res.has_value = 1'b1;
                    res.top_value = model_stack[model_count-1];
                end
            end
            rsa_pkg::CMD_SHL, rsa_pkg::CMD_SHR, rsa_pkg::CMD_OR, rsa_pkg::CMD_AND,
            rsa_pkg::CMD_ADD: begin
                if (model_count >= 2) begin
                    r = combine_top(w.cmd, model_stack[model_count-1],
                                    model_stack[model_count-2]);
                    model_count--;
                    model_stack[model_count-1] = r;
                    res.has_value = 1'b1;
                    res.top_value = r;
                end
            end
            default: res.has_value = 1'b1;
        endcase
        return res;
    endfunction

    // predict on input acceptance, then check on output acceptance
    always @(posedge i_clk) begin
        rsa_pkg::t_out_word want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pending_results.insert(pending_results.size(), stack_result(i_in_word));
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result word %h", $realtime, o_out_word);
                    mismatch_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_word.has_value !== want.has_value) begin
                        $display("%0t: has_value expected %0d actual %0d", $realtime,
                                 want.has_value, o_out_word.has_value);
                        mismatch_cnt++;
                    end
                    if (o_out_word.top_value !== want.top_value) begin
                        $display("%0t: top_value expected %h actual %h", $realtime,
                                 want.top_value, o_out_word.top_value);
                        mismatch_cnt++;
                    end
                    if (o_out_word.overflow !== want.overflow) begin
                        $display("%0t: overflow expected %0d actual %0d", $realtime,
                                 want.overflow, o_out_word.overflow);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stall the result side in random bursts
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= '{cmd: cmd, value: value};
        do @(posedge i_clk); while (!o_in_ready);
        case (cmd)
            rsa_pkg::CMD_LOAD:  if (gen_depth < DEPTH) gen_depth++;
            rsa_pkg::CMD_EMPTY: gen_depth = 0;
            rsa_pkg::CMD_POP:   if (gen_depth > 0) gen_depth--;
            rsa_pkg::CMD_SHL, rsa_pkg::CMD_SHR, rsa_pkg::CMD_OR, rsa_pkg::CMD_AND,
            rsa_pkg::CMD_ADD: if (gen_depth >= 2) gen_depth--;
            default: ;
        endcase
    endtask

    task automatic test_empty_stack();
        send_word(rsa_pkg::CMD_TOP, 16'h1234);
        send_word(rsa_pkg::CMD_POP, 16'hFFFF);
        send_word(rsa_pkg::CMD_ADD, 16'h0000);
        send_word(rsa_pkg::CMD_SHL, 16'h0001);
        send_word(CMD_UNKNOWN_LO, 16'hFFFF);
        send_word(rsa_pkg::CMD_LOAD, 16'h00AA);
        send_word(rsa_pkg::CMD_OR, 16'h5555);
    endtask

    task automatic test_each_operation();
        send_word(rsa_pkg::CMD_EMPTY, 16'h0000);
        send_word(rsa_pkg::CMD_LOAD, 16'hFFFF);
        send_word(rsa_pkg::CMD_LOAD, 16'h0001);
        send_word(rsa_pkg::CMD_ADD, 16'h0000);
        send_word(rsa_pkg::CMD_LOAD, 16'h8001);
        send_word(rsa_pkg::CMD_LOAD, 16'h000F);
        send_word(rsa_pkg::CMD_SHL, 16'h0000);
        send_word(rsa_pkg::CMD_LOAD, 16'h0010);
        send_word(rsa_pkg::CMD_SHR, 16'h0000);
        send_word(rsa_pkg::CMD_LOAD, 16'hFFFF);
        send_word(rsa_pkg::CMD_OR, 16'h0000);
        send_word(rsa_pkg::CMD_LOAD, 16'h0F0F);
        send_word(rsa_pkg::CMD_AND, 16'h0000);
        send_word(rsa_pkg::CMD_LOAD, 16'h0004);
        send_word(rsa_pkg::CMD_SHR, 16'h0000);
        send_word(rsa_pkg::CMD_LOAD, 16'hFFFF);
        send_word(rsa_pkg::CMD_SHL, 16'h0000);
        send_word(rsa_pkg::CMD_TOP, 16'h0000);
        send_word(rsa_pkg::CMD_POP, 16'h0000);
        send_word(rsa_pkg::CMD_POP, 16'h0000);
        send_word(CMD_UNKNOWN_HI, 16'h0000);
        send_word(rsa_pkg::CMD_EMPTY, 16'hFFFF);
    endtask

    task automatic test_full_stack();
        send_word(rsa_pkg::CMD_EMPTY, 16'h0000);
        repeat (DEPTH) send_word(rsa_pkg::CMD_LOAD, 16'($urandom));
        send_word(rsa_pkg::CMD_LOAD, 16'hFFFF);
        send_word(rsa_pkg::CMD_TOP, 16'h0000);
        send_word(rsa_pkg::CMD_ADD, 16'h0000);
        send_word(rsa_pkg::CMD_LOAD, 16'h0000);
        send_word(rsa_pkg::CMD_LOAD, 16'h7777);
        send_word(rsa_pkg::CMD_EMPTY, 16'h0000);
        send_word(rsa_pkg::CMD_TOP, 16'h0000);
    endtask

    task automatic test_random_programs(input int unsigned n, input int unsigned enter_pct);
        int unsigned       pick;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
        send_word(rsa_pkg::CMD_EMPTY, 16'($urandom));
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) cmd = CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
            else if (pick < 7) cmd = rsa_pkg::CMD_EMPTY;
            else if (pick < 12) cmd = rsa_pkg::CMD_POP;
            else if (pick < 17) cmd = rsa_pkg::CMD_TOP;
            else if (gen_depth < 2 || $urandom_range(0, 99) < enter_pct) begin
                cmd = rsa_pkg::CMD_LOAD;
            end else begin
                cmd = CMD_W'($urandom_range(rsa_pkg::CMD_SHL, rsa_pkg::CMD_ADD));
            end
            case ($urandom_range(0, 5))
                0, 1: value = DATA_W'($urandom_range(0, 20));
                2: begin
                    case ($urandom_range(0, 2))
                        0: value = 16'h0000;
                        1: value = 16'hFFFF;
                        default: value = 16'h8000;
                    endcase
                end
                default: value = DATA_W'($urandom);
            endcase
            send_word(cmd, value);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_word    = '0;
        mismatch_cnt = 0;
        quiet_cycles = 0;
        gen_depth    = 0;
        model_count  = 0;
        idle_on      = 1'b1;
        stall_on     = 1'b1;
        foreach (model_stack[k]) model_stack[k] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_stack();
        test_each_operation();
        test_full_stack();
        test_random_programs(350, 55);
        test_random_programs(250, 80);
        idle_on = 1'b0;
        test_random_programs(150, 60);
        stall_on = 1'b0;
        test_random_programs(350, 60);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
